// File: hw/rtl/mrtl_pkg.sv
package mrtl_pkg;

    // Grid and table geometry
    localparam int GRID_X  = 8;
    localparam int GRID_Y  = 8;
    localparam int ENTRIES = 64;
    localparam int CHIPS   = GRID_X * GRID_Y;

    localparam int CHIP_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TADDR_W = (CHIPS * ENTRIES > 1) ? $clog2(CHIPS * ENTRIES) : 1;

    // Fixed mask applied to the source key before the search
    localparam logic [31:0] SRC_MASK = 32'hffff_f800;

    // Item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // One stored table entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] mask;
        logic [31:0] data;
    } t_entry;

    // Input transaction
    typedef struct packed {
        logic        mode;
        logic [2:0]  chip_x;
        logic [2:0]  chip_y;
        logic [31:0] source_key;
        logic [31:0] entry_key;
        logic [31:0] entry_mask;
        logic [31:0] entry_data;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [31:0] route_data;
        logic        hit;
        logic        status;
    } t_out_item;

endpackage

// File: hw/rtl/mrtl_ram.sv
module mrtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/multicast_route_table_lookup.sv
// A load passes S_CNT and its result is then registered; a lookup that stops at
// entry k (0-based) reads entries 0 to k in S_CNT and S_SCAN, then registers
// its result. One transaction at a time; the table memory read port, one entry
// per cycle, sets the lookup time. A waiting result does not block acceptance.
// Reset: synchronous, clears the per-chip count valid bits and the control
// state; table contents stay undefined, no clearing pass.
module multicast_route_table_lookup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mrtl_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mrtl_pkg::t_out_item  o_out_item
);

    import mrtl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CNT  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [CHIP_W-1:0] r_chip;
    logic              r_in_grid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_cnt_vld [CHIPS];
    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_accept;
    logic              out_free;
    logic              in_grid;
    logic [CHIP_W-1:0] chip;
    logic [CNT_W-1:0]  cnt_q;
    logic [CNT_W-1:0]  cnt_cur;
    logic              cnt_we;
    logic              tbl_we;
    logic              tbl_re;
    logic [IDX_W-1:0]  tbl_ridx;
    t_entry            tbl_q;
    t_entry            tbl_wdata;
    logic              match;
    logic              last;
    logic              out_load;
    t_out_item         n_res;

    function automatic logic [TADDR_W-1:0] tbl_addr(input logic [CHIP_W-1:0] c,
                                                    input logic [IDX_W-1:0] e);
        return TADDR_W'(c) * TADDR_W'(ENTRIES) + TADDR_W'(e);
    endfunction

    // Handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Chip index from the incoming coordinates
    assign in_grid = (32'(i_in_item.chip_x) < GRID_X) && (32'(i_in_item.chip_y) < GRID_Y);
    assign chip    = CHIP_W'(32'(i_in_item.chip_x) * GRID_Y + 32'(i_in_item.chip_y));

    // Per-chip entry counts; an unwritten count reads as zero
    mrtl_ram #(.WIDTH(CNT_W), .DEPTH(CHIPS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_chip),
        .i_wdata (cnt_cur + CNT_W'(1)),
        .i_re    (in_accept),
        .i_raddr (chip),
        .o_rdata (cnt_q)
    );

    assign cnt_cur = r_cnt_vld[r_chip] ? cnt_q : '0;

    // Table entries of all chips
    assign tbl_wdata = '{key: r_item.entry_key, mask: r_item.entry_mask,
                         data: r_item.entry_data};

    mrtl_ram #(.WIDTH($bits(t_entry)), .DEPTH(CHIPS * ENTRIES)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_addr(r_chip, cnt_cur[IDX_W-1:0])),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_addr(r_chip, tbl_ridx)),
        .o_rdata (tbl_q)
    );

    // Search compare on the entry just read
    assign match = ((tbl_q.key & tbl_q.mask) == (r_item.source_key & SRC_MASK));
    assign last  = ((r_idx + CNT_W'(1)) == r_cnt);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        cnt_we   = 1'b0;
        tbl_we   = 1'b0;
        tbl_re   = 1'b0;
        tbl_ridx = '0;
        out_load = 1'b0;
        n_res    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                if (!r_in_grid) begin
                    if (out_free) begin
                        n_res.status = (r_item.mode == MODE_LOAD);
                        out_load     = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (r_item.mode == MODE_LOAD) begin
                    if (out_free) begin
                        if (cnt_cur >= CNT_W'(ENTRIES)) begin
                            n_res.status = 1'b1;
                        end else begin
                            tbl_we = 1'b1;
                            cnt_we = 1'b1;
                        end
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (cnt_cur == '0) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    tbl_re  = 1'b1;
                    n_idx   = '0;
                    n_cnt   = cnt_cur;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || last) begin
                    if (out_free) begin
                        n_res.route_data = match ? tbl_q.data : '0;
                        n_res.hit        = match;
                        out_load         = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    tbl_re   = 1'b1;
                    tbl_ridx = IDX_W'(r_idx + CNT_W'(1));
                    n_idx    = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Count valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHIPS; c++) begin
                r_cnt_vld[c] <= 1'b0;
            end
        end else if (cnt_we) begin
            r_cnt_vld[r_chip] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item    <= i_in_item;
            r_chip    <= chip;
            r_in_grid <= in_grid;
        end
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        if (out_load) begin
            r_out <= n_res;
        end
    end

    // Checks
    a_hit_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.status))
        else $error("hit and status both set");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |-> (r_out.route_data == '0))
        else $error("route data nonzero without a hit");

    a_write_in_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_we || cnt_we) |-> (r_state == S_CNT && r_item.mode == MODE_LOAD))
        else $error("table written outside a load");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_cnt))
        else $error("scan index past entry count");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CNT))
        else $error("accepted transaction not started");

endmodule
